### rtl/mic_pkg.sv
// ----------------------------------------------------------------------------
// mic_pkg: shared types, constants and the microcode program
// Widths of the moment accumulators, the wide datapath word, the instruction
// format of the shared arithmetic unit and its program are kept here.
// ----------------------------------------------------------------------------
package mic_pkg;

    localparam int COORD_BITS    = 11;
    localparam int COUNT_BITS    = 22;
    localparam int OUT_FRAC_BITS = 24;

    localparam int PIX_W = 11;
    localparam int OUT_W = 32;

    localparam int CNT_W = COUNT_BITS + 1;
    localparam int S1_W  = COUNT_BITS + COORD_BITS;
    localparam int S2_W  = COUNT_BITS + 2 * COORD_BITS;
    localparam int S3_W  = COUNT_BITS + 3 * COORD_BITS;

    // Wide signed word of the shared unit; the largest intermediate value
    // (ninth power of the count shifted by the output width) stays well below.
    localparam int BW       = 256;
    localparam int RA_W     = 5;
    localparam int RF_DEPTH = 30;
    localparam int IMM_W    = 14;
    localparam int SEL_W    = 4;
    localparam int PC_W     = 8;
    localparam int PROG_LEN = 153;
    localparam int THR_BASE = 93;

    localparam int NUM_INV     = 5;
    localparam int NUM_LETTERS = 3;

    localparam logic [1:0] LT_C = 2'd0;
    localparam logic [1:0] LT_I = 2'd1;
    localparam logic [1:0] LT_T = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_OVFL  = 2'd2;

    // Register file addresses.
    localparam logic [RA_W-1:0] RG_N    = 5'd0;
    localparam logic [RA_W-1:0] RG_SX   = 5'd1;
    localparam logic [RA_W-1:0] RG_SY   = 5'd2;
    localparam logic [RA_W-1:0] RG_SXX  = 5'd3;
    localparam logic [RA_W-1:0] RG_SYY  = 5'd4;
    localparam logic [RA_W-1:0] RG_SXY  = 5'd5;
    localparam logic [RA_W-1:0] RG_SXXX = 5'd6;
    localparam logic [RA_W-1:0] RG_SYYY = 5'd7;
    localparam logic [RA_W-1:0] RG_SXXY = 5'd8;
    localparam logic [RA_W-1:0] RG_SXYY = 5'd9;
    localparam logic [RA_W-1:0] RG_N2   = 5'd10;
    localparam logic [RA_W-1:0] RG_N3   = 5'd11;
    localparam logic [RA_W-1:0] RG_N6   = 5'd12;
    localparam logic [RA_W-1:0] RG_N9   = 5'd13;
    localparam logic [RA_W-1:0] RG_SX2  = 5'd14;
    localparam logic [RA_W-1:0] RG_SY2  = 5'd15;
    localparam logic [RA_W-1:0] RG_A20  = 5'd16;
    localparam logic [RA_W-1:0] RG_A02  = 5'd17;
    localparam logic [RA_W-1:0] RG_A11  = 5'd18;
    localparam logic [RA_W-1:0] RG_B30  = 5'd19;
    localparam logic [RA_W-1:0] RG_B03  = 5'd20;
    localparam logic [RA_W-1:0] RG_B21  = 5'd21;
    localparam logic [RA_W-1:0] RG_B12  = 5'd22;
    localparam logic [RA_W-1:0] RG_U0   = 5'd23;
    localparam logic [RA_W-1:0] RG_U1   = 5'd24;
    localparam logic [RA_W-1:0] RG_U2   = 5'd25;
    localparam logic [RA_W-1:0] RG_U3   = 5'd26;
    localparam logic [RA_W-1:0] RG_U4   = 5'd27;
    localparam logic [RA_W-1:0] RG_T1   = 5'd28;
    localparam logic [RA_W-1:0] RG_T2   = 5'd29;

    typedef enum logic [3:0] {
        OP_NOP  = 4'd0,
        OP_INIT = 4'd1,
        OP_LD   = 4'd2,
        OP_ADD  = 4'd3,
        OP_SUB  = 4'd4,
        OP_MUL  = 4'd5,
        OP_MULK = 4'd6,
        OP_CGT  = 4'd7,
        OP_CLT  = 4'd8,
        OP_DIV  = 4'd9
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [RA_W-1:0]  dst;
        logic [RA_W-1:0]  a;
        logic [RA_W-1:0]  b;
        logic [SEL_W-1:0] sel;
        logic [IMM_W-1:0] imm;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [S1_W-1:0]  sx;
        logic [S1_W-1:0]  sy;
        logic [S2_W-1:0]  sxx;
        logic [S2_W-1:0]  syy;
        logic [S2_W-1:0]  sxy;
        logic [S3_W-1:0]  sxxx;
        logic [S3_W-1:0]  syyy;
        logic [S3_W-1:0]  sxxy;
        logic [S3_W-1:0]  sxyy;
    } t_sums;

    typedef struct packed {
        logic [2:0]       inv;
        logic [IMM_W-1:0] lo;
        logic [IMM_W-1:0] hi;
        logic [1:0]       letter;
    } t_win;

    // Letter windows in units of 1/10000; a lower bound of zero means none.
    function automatic t_win win(input logic [3:0] w);
        t_win r;
        r = '0;
        case (w)
            4'd0:    r = '{3'd0, 14'd3500, 14'd5300, LT_C};
            4'd1:    r = '{3'd1, 14'd0,    14'd500,  LT_C};
            4'd2:    r = '{3'd2, 14'd10,   14'd300,  LT_C};
            4'd3:    r = '{3'd3, 14'd10,   14'd200,  LT_C};
            4'd4:    r = '{3'd4, 14'd200,  14'd700,  LT_C};
            4'd5:    r = '{3'd0, 14'd2800, 14'd7000, LT_I};
            4'd6:    r = '{3'd1, 14'd600,  14'd3200, LT_I};
            4'd7:    r = '{3'd2, 14'd0,    14'd20,   LT_I};
            4'd8:    r = '{3'd3, 14'd0,    14'd20,   LT_I};
            4'd9:    r = '{3'd4, 14'd10,   14'd100,  LT_I};
            4'd10:   r = '{3'd0, 14'd3000, 14'd7000, LT_T};
            4'd11:   r = '{3'd1, 14'd500,  14'd3500, LT_T};
            4'd12:   r = '{3'd2, 14'd20,   14'd500,  LT_T};
            4'd13:   r = '{3'd3, 14'd5,    14'd300,  LT_T};
            4'd14:   r = '{3'd4, 14'd100,  14'd190,  LT_T};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [RA_W-1:0] den_reg(input logic [2:0] inv);
        logic [RA_W-1:0] r;
        case (inv)
            3'd1, 3'd4: r = RG_N6;
            3'd2, 3'd3: r = RG_N9;
            default:    r = RG_N3;
        endcase
        return r;
    endfunction

    function automatic t_cmd mk(input t_op op, input logic [RA_W-1:0] d,
                                input logic [RA_W-1:0] a, input logic [RA_W-1:0] b,
                                input logic [SEL_W-1:0] sel, input logic [IMM_W-1:0] imm);
        t_cmd c;
        c.op  = op;
        c.dst = d;
        c.a   = a;
        c.b   = b;
        c.sel = sel;
        c.imm = imm;
        return c;
    endfunction

    // Program: load sums, form powers of N, central moments, numerators,
    // quotients, scaling of the numerators by 10000, then the threshold tests.
    function automatic t_cmd prog(input logic [PC_W-1:0] pc);
        t_cmd            c;
        logic [PC_W-1:0] t;
        t_win            wn;
        logic [RA_W-1:0] u;
        logic [RA_W-1:0] dn;
        c  = mk(OP_NOP, RG_T1, RG_T1, RG_T1, 4'd0, 14'd0);
        t  = pc - PC_W'(THR_BASE);
        wn = win(t[5:2]);
        u  = RG_U0 + {2'b00, wn.inv};
        dn = den_reg(wn.inv);
        case (pc)
            8'd0:  c = mk(OP_INIT, RG_T1, RG_T1, RG_T1, 4'd0, 14'd0);
            8'd1:  c = mk(OP_LD, RG_N,    RG_T1, RG_T1, 4'd0, 14'd0);
            8'd2:  c = mk(OP_LD, RG_SX,   RG_T1, RG_T1, 4'd1, 14'd0);
            8'd3:  c = mk(OP_LD, RG_SY,   RG_T1, RG_T1, 4'd2, 14'd0);
            8'd4:  c = mk(OP_LD, RG_SXX,  RG_T1, RG_T1, 4'd3, 14'd0);
            8'd5:  c = mk(OP_LD, RG_SYY,  RG_T1, RG_T1, 4'd4, 14'd0);
            8'd6:  c = mk(OP_LD, RG_SXY,  RG_T1, RG_T1, 4'd5, 14'd0);
            8'd7:  c = mk(OP_LD, RG_SXXX, RG_T1, RG_T1, 4'd6, 14'd0);
            8'd8:  c = mk(OP_LD, RG_SYYY, RG_T1, RG_T1, 4'd7, 14'd0);
            8'd9:  c = mk(OP_LD, RG_SXXY, RG_T1, RG_T1, 4'd8, 14'd0);
            8'd10: c = mk(OP_LD, RG_SXYY, RG_T1, RG_T1, 4'd9, 14'd0);
            8'd11: c = mk(OP_MUL, RG_N2,  RG_N,   RG_N,   4'd0, 14'd0);
            8'd12: c = mk(OP_MUL, RG_N3,  RG_N2,  RG_N,   4'd0, 14'd0);
            8'd13: c = mk(OP_MUL, RG_N6,  RG_N3,  RG_N3,  4'd0, 14'd0);
            8'd14: c = mk(OP_MUL, RG_N9,  RG_N6,  RG_N3,  4'd0, 14'd0);
            8'd15: c = mk(OP_MUL, RG_SX2, RG_SX,  RG_SX,  4'd0, 14'd0);
            8'd16: c = mk(OP_MUL, RG_SY2, RG_SY,  RG_SY,  4'd0, 14'd0);
            8'd17: c = mk(OP_MUL, RG_T1,  RG_N,   RG_SXX, 4'd0, 14'd0);
            8'd18: c = mk(OP_SUB, RG_A20, RG_T1,  RG_SX2, 4'd0, 14'd0);
            8'd19: c = mk(OP_MUL, RG_T1,  RG_N,   RG_SYY, 4'd0, 14'd0);
            8'd20: c = mk(OP_SUB, RG_A02, RG_T1,  RG_SY2, 4'd0, 14'd0);
            8'd21: c = mk(OP_MUL, RG_T1,  RG_N,   RG_SXY, 4'd0, 14'd0);
            8'd22: c = mk(OP_MUL, RG_T2,  RG_SX,  RG_SY,  4'd0, 14'd0);
            8'd23: c = mk(OP_SUB, RG_A11, RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd24: c = mk(OP_MUL, RG_T1,  RG_N2,  RG_SXXX, 4'd0, 14'd0);
            8'd25: c = mk(OP_MUL, RG_T2,  RG_SXX, RG_SX,  4'd0, 14'd0);
            8'd26: c = mk(OP_MUL, RG_T2,  RG_T2,  RG_N,   4'd0, 14'd0);
            8'd27: c = mk(OP_MULK, RG_T2, RG_T2,  RG_T2,  4'd0, 14'd3);
            8'd28: c = mk(OP_SUB, RG_T1,  RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd29: c = mk(OP_MUL, RG_T2,  RG_SX2, RG_SX,  4'd0, 14'd0);
            8'd30: c = mk(OP_MULK, RG_T2, RG_T2,  RG_T2,  4'd0, 14'd2);
            8'd31: c = mk(OP_ADD, RG_B30, RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd32: c = mk(OP_MUL, RG_T1,  RG_N2,  RG_SYYY, 4'd0, 14'd0);
            8'd33: c = mk(OP_MUL, RG_T2,  RG_SYY, RG_SY,  4'd0, 14'd0);
            8'd34: c = mk(OP_MUL, RG_T2,  RG_T2,  RG_N,   4'd0, 14'd0);
            8'd35: c = mk(OP_MULK, RG_T2, RG_T2,  RG_T2,  4'd0, 14'd3);
            8'd36: c = mk(OP_SUB, RG_T1,  RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd37: c = mk(OP_MUL, RG_T2,  RG_SY2, RG_SY,  4'd0, 14'd0);
            8'd38: c = mk(OP_MULK, RG_T2, RG_T2,  RG_T2,  4'd0, 14'd2);
            8'd39: c = mk(OP_ADD, RG_B03, RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd40: c = mk(OP_MUL, RG_T1,  RG_N2,  RG_SXXY, 4'd0, 14'd0);
            8'd41: c = mk(OP_MUL, RG_T2,  RG_SXY, RG_SX,  4'd0, 14'd0);
            8'd42: c = mk(OP_MUL, RG_T2,  RG_T2,  RG_N,   4'd0, 14'd0);
            8'd43: c = mk(OP_MULK, RG_T2, RG_T2,  RG_T2,  4'd0, 14'd2);
            8'd44: c = mk(OP_SUB, RG_T1,  RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd45: c = mk(OP_MUL, RG_T2,  RG_SXX, RG_SY,  4'd0, 14'd0);
            8'd46: c = mk(OP_MUL, RG_T2,  RG_T2,  RG_N,   4'd0, 14'd0);
            8'd47: c = mk(OP_SUB, RG_T1,  RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd48: c = mk(OP_MUL, RG_T2,  RG_SY,  RG_SX2, 4'd0, 14'd0);
            8'd49: c = mk(OP_MULK, RG_T2, RG_T2,  RG_T2,  4'd0, 14'd2);
            8'd50: c = mk(OP_ADD, RG_B21, RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd51: c = mk(OP_MUL, RG_T1,  RG_N2,  RG_SXYY, 4'd0, 14'd0);
            8'd52: c = mk(OP_MUL, RG_T2,  RG_SXY, RG_SY,  4'd0, 14'd0);
            8'd53: c = mk(OP_MUL, RG_T2,  RG_T2,  RG_N,   4'd0, 14'd0);
            8'd54: c = mk(OP_MULK, RG_T2, RG_T2,  RG_T2,  4'd0, 14'd2);
            8'd55: c = mk(OP_SUB, RG_T1,  RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd56: c = mk(OP_MUL, RG_T2,  RG_SYY, RG_SX,  4'd0, 14'd0);
            8'd57: c = mk(OP_MUL, RG_T2,  RG_T2,  RG_N,   4'd0, 14'd0);
            8'd58: c = mk(OP_SUB, RG_T1,  RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd59: c = mk(OP_MUL, RG_T2,  RG_SX,  RG_SY2, 4'd0, 14'd0);
            8'd60: c = mk(OP_MULK, RG_T2, RG_T2,  RG_T2,  4'd0, 14'd2);
            8'd61: c = mk(OP_ADD, RG_B12, RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd62: c = mk(OP_ADD, RG_U0,  RG_A20, RG_A02, 4'd0, 14'd0);
            8'd63: c = mk(OP_SUB, RG_T1,  RG_A20, RG_A02, 4'd0, 14'd0);
            8'd64: c = mk(OP_MUL, RG_T1,  RG_T1,  RG_T1,  4'd0, 14'd0);
            8'd65: c = mk(OP_MUL, RG_T2,  RG_A11, RG_A11, 4'd0, 14'd0);
            8'd66: c = mk(OP_MULK, RG_T2, RG_T2,  RG_T2,  4'd0, 14'd4);
            8'd67: c = mk(OP_ADD, RG_U1,  RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd68: c = mk(OP_MULK, RG_T1, RG_B12, RG_B12, 4'd0, 14'd3);
            8'd69: c = mk(OP_SUB, RG_T1,  RG_B30, RG_T1,  4'd0, 14'd0);
            8'd70: c = mk(OP_MUL, RG_T1,  RG_T1,  RG_T1,  4'd0, 14'd0);
            8'd71: c = mk(OP_MULK, RG_T2, RG_B21, RG_B21, 4'd0, 14'd3);
            8'd72: c = mk(OP_SUB, RG_T2,  RG_T2,  RG_B03, 4'd0, 14'd0);
            8'd73: c = mk(OP_MUL, RG_T2,  RG_T2,  RG_T2,  4'd0, 14'd0);
            8'd74: c = mk(OP_ADD, RG_U2,  RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd75: c = mk(OP_ADD, RG_T1,  RG_B30, RG_B12, 4'd0, 14'd0);
            8'd76: c = mk(OP_MUL, RG_T1,  RG_T1,  RG_T1,  4'd0, 14'd0);
            8'd77: c = mk(OP_ADD, RG_T2,  RG_B21, RG_B03, 4'd0, 14'd0);
            8'd78: c = mk(OP_MUL, RG_T2,  RG_T2,  RG_T2,  4'd0, 14'd0);
            8'd79: c = mk(OP_ADD, RG_U3,  RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd80: c = mk(OP_MUL, RG_T1,  RG_A20, RG_A02, 4'd0, 14'd0);
            8'd81: c = mk(OP_MUL, RG_T2,  RG_A11, RG_A11, 4'd0, 14'd0);
            8'd82: c = mk(OP_SUB, RG_U4,  RG_T1,  RG_T2,  4'd0, 14'd0);
            8'd83: c = mk(OP_DIV, RG_T1,  RG_U0,  RG_N3,  4'd0, 14'd0);
            8'd84: c = mk(OP_DIV, RG_T1,  RG_U1,  RG_N6,  4'd1, 14'd0);
            8'd85: c = mk(OP_DIV, RG_T1,  RG_U2,  RG_N9,  4'd2, 14'd0);
            8'd86: c = mk(OP_DIV, RG_T1,  RG_U3,  RG_N9,  4'd3, 14'd0);
            8'd87: c = mk(OP_DIV, RG_T1,  RG_U4,  RG_N6,  4'd4, 14'd0);
            8'd88: c = mk(OP_MULK, RG_U0, RG_U0,  RG_U0,  4'd0, 14'd10000);
            8'd89: c = mk(OP_MULK, RG_U1, RG_U1,  RG_U1,  4'd0, 14'd10000);
            8'd90: c = mk(OP_MULK, RG_U2, RG_U2,  RG_U2,  4'd0, 14'd10000);
            8'd91: c = mk(OP_MULK, RG_U3, RG_U3,  RG_U3,  4'd0, 14'd10000);
            8'd92: c = mk(OP_MULK, RG_U4, RG_U4,  RG_U4,  4'd0, 14'd10000);
            default: begin
                // Four steps per window: scale the denominator by the lower
                // bound and test, then the same for the upper bound.
                if (pc >= PC_W'(THR_BASE) && pc < PC_W'(PROG_LEN)) begin
                    case (t[1:0])
                        2'd0: if (wn.lo != '0)
                                  c = mk(OP_MULK, RG_T1, dn, dn, 4'd0, wn.lo);
                        2'd1: if (wn.lo != '0)
                                  c = mk(OP_CGT, RG_T1, u, RG_T1, {2'b00, wn.letter}, 14'd0);
                        2'd2: c = mk(OP_MULK, RG_T1, dn, dn, 4'd0, wn.hi);
                        default: c = mk(OP_CLT, RG_T1, u, RG_T1, {2'b00, wn.letter}, 14'd0);
                    endcase
                end
            end
        endcase
        return c;
    endfunction

endpackage

### rtl/mic_pix_if.sv
// ----------------------------------------------------------------------------
// mic_pix_if: pixel input channel
// Valid/ready channel carrying one segment pixel and its end marker.
// ----------------------------------------------------------------------------
interface mic_pix_if;
    import mic_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input last_pixel,
                    output ready);
endinterface

### rtl/mic_res_if.sv
// ----------------------------------------------------------------------------
// mic_res_if: result output channel
// Valid/ready channel carrying the invariants, letter flags and status.
// ----------------------------------------------------------------------------
interface mic_res_if;
    import mic_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] inv_m1;
    logic [OUT_W-1:0] inv_m2;
    logic [OUT_W-1:0] inv_m3;
    logic [OUT_W-1:0] inv_m4;
    logic [OUT_W-1:0] inv_m7;
    logic             looks_like_c;
    logic             looks_like_i;
    logic             looks_like_t;
    logic [1:0]       status;

    modport source (output valid, output inv_m1, output inv_m2, output inv_m3,
                    output inv_m4, output inv_m7, output looks_like_c,
                    output looks_like_i, output looks_like_t, output status,
                    input ready);
    modport sink   (input valid, input inv_m1, input inv_m2, input inv_m3,
                    input inv_m4, input inv_m7, input looks_like_c,
                    input looks_like_i, input looks_like_t, input status,
                    output ready);
endinterface

### rtl/mic_accum.sv
// ----------------------------------------------------------------------------
// mic_accum: raw moment accumulator
// Three-stage pipeline that adds one pixel per cycle into the pixel count
// and the nine raw moment sums up to third order.
// ----------------------------------------------------------------------------
module mic_accum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [mic_pkg::COORD_BITS-1:0] i_x,
    input  logic [mic_pkg::COORD_BITS-1:0] i_y,
    input  logic                         i_clr,
    output mic_pkg::t_sums               o_sums
);
    import mic_pkg::*;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'((1 << COUNT_BITS) - 1);
    localparam logic [CNT_W-1:0] COUNT_OVF = CNT_W'(1 << COUNT_BITS);

    t_sums                    r_sums;
    logic                     r_v1;
    logic                     r_v2;
    logic [COORD_BITS-1:0]    r_x1;
    logic [COORD_BITS-1:0]    r_y1;
    logic [COORD_BITS-1:0]    r_x2;
    logic [COORD_BITS-1:0]    r_y2;
    logic [2*COORD_BITS-1:0]  r_xx2;
    logic [2*COORD_BITS-1:0]  r_xy2;
    logic [2*COORD_BITS-1:0]  r_yy2;
    logic [3*COORD_BITS-1:0]  p_xxx;
    logic [3*COORD_BITS-1:0]  p_xxy;
    logic [3*COORD_BITS-1:0]  p_xyy;
    logic [3*COORD_BITS-1:0]  p_yyy;

    assign p_xxx = r_xx2 * r_x2;
    assign p_xxy = r_xx2 * r_y2;
    assign p_xyy = r_yy2 * r_x2;
    assign p_yyy = r_yy2 * r_y2;
    assign o_sums = r_sums;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_sums <= '0;
        end else begin
            r_v1 <= 1'b0;
            if (i_valid) begin
                // Once the count is full, further pixels only mark overflow.
                if (r_sums.n < COUNT_MAX) begin
                    r_sums.n <= r_sums.n + 1'b1;
                    r_v1     <= 1'b1;
                end else begin
                    r_sums.n <= COUNT_OVF;
                end
            end
            r_v2 <= r_v1;
            if (r_v2) begin
                r_sums.sx   <= r_sums.sx + S1_W'(r_x2);
                r_sums.sy   <= r_sums.sy + S1_W'(r_y2);
                r_sums.sxx  <= r_sums.sxx + S2_W'(r_xx2);
                r_sums.syy  <= r_sums.syy + S2_W'(r_yy2);
                r_sums.sxy  <= r_sums.sxy + S2_W'(r_xy2);
                r_sums.sxxx <= r_sums.sxxx + S3_W'(p_xxx);
                r_sums.syyy <= r_sums.syyy + S3_W'(p_yyy);
                r_sums.sxxy <= r_sums.sxxy + S3_W'(p_xxy);
                r_sums.sxyy <= r_sums.sxyy + S3_W'(p_xyy);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1  <= i_x;
        r_y1  <= i_y;
        r_x2  <= r_x1;
        r_y2  <= r_y1;
        r_xx2 <= r_x1 * r_x1;
        r_xy2 <= r_x1 * r_y1;
        r_yy2 <= r_y1 * r_y1;
    end

endmodule

### rtl/mic_core.sv
// ----------------------------------------------------------------------------
// mic_core: shared wide arithmetic unit
// Register file of wide signed words with one shift-add multiplier, one
// adder/comparator and a restoring divider, executing one command at a time.
// ----------------------------------------------------------------------------
module mic_core (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_start,
    input  mic_pkg::t_cmd                                  i_cmd,
    input  mic_pkg::t_sums                                 i_sums,
    output logic                                           o_done,
    output logic [mic_pkg::NUM_INV-1:0][mic_pkg::OUT_W-1:0] o_quot,
    output logic [mic_pkg::NUM_LETTERS-1:0]                o_ok
);
    import mic_pkg::*;

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_RD   = 5'b00010,
        C_EX   = 5'b00100,
        C_MUL  = 5'b01000,
        C_DIV  = 5'b10000
    } t_cst;

    t_cst                          r_st, n_st;
    t_cmd                          r_cmd, n_cmd;
    logic [BW-1:0]                 r_rf [RF_DEPTH];
    logic [BW-1:0]                 r_qa, r_qb;
    logic [BW-1:0]                 r_acc, n_acc;
    logic [BW-1:0]                 r_mc, n_mc;
    logic [BW-1:0]                 r_mp, n_mp;
    logic [4:0]                    r_cnt, n_cnt;
    logic [OUT_W-1:0]              r_q, n_q;
    logic [NUM_INV-1:0][OUT_W-1:0] r_quot, n_quot;
    logic [NUM_LETTERS-1:0]        r_ok, n_ok;
    logic                          r_done, n_done;
    logic                          we;
    logic [BW-1:0]                 wd;
    logic [BW-1:0]                 sum_v;
    logic [BW-1:0]                 num_sh;
    logic [BW-1:0]                 den_sh;

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_ok   = r_ok;
    assign num_sh = r_qa << OUT_FRAC_BITS;
    assign den_sh = r_qb << OUT_W;

    always_comb begin
        case (r_cmd.sel)
            4'd0:    sum_v = BW'(i_sums.n);
            4'd1:    sum_v = BW'(i_sums.sx);
            4'd2:    sum_v = BW'(i_sums.sy);
            4'd3:    sum_v = BW'(i_sums.sxx);
            4'd4:    sum_v = BW'(i_sums.syy);
            4'd5:    sum_v = BW'(i_sums.sxy);
            4'd6:    sum_v = BW'(i_sums.sxxx);
            4'd7:    sum_v = BW'(i_sums.syyy);
            4'd8:    sum_v = BW'(i_sums.sxxy);
            4'd9:    sum_v = BW'(i_sums.sxyy);
            default: sum_v = '0;
        endcase
    end

    always_comb begin
        n_st   = r_st;
        n_cmd  = r_cmd;
        n_acc  = r_acc;
        n_mc   = r_mc;
        n_mp   = r_mp;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_quot = r_quot;
        n_ok   = r_ok;
        n_done = 1'b0;
        we     = 1'b0;
        wd     = r_acc;
        unique case (r_st)
            C_IDLE: begin
                if (i_start) begin
                    n_cmd = i_cmd;
                    n_st  = C_RD;
                end
            end
            C_RD: n_st = C_EX;
            C_EX: begin
                n_st   = C_IDLE;
                n_done = 1'b1;
                unique case (r_cmd.op)
                    OP_NOP:  ;
                    OP_INIT: n_ok = '1;
                    OP_LD: begin
                        we = 1'b1;
                        wd = sum_v;
                    end
                    OP_ADD: begin
                        we = 1'b1;
                        wd = r_qa + r_qb;
                    end
                    OP_SUB: begin
                        we = 1'b1;
                        wd = r_qa - r_qb;
                    end
                    OP_MUL: begin
                        // A negative multiplier is handled by negating both sides.
                        n_acc  = '0;
                        n_mc   = r_qb[BW-1] ? -r_qa : r_qa;
                        n_mp   = r_qb[BW-1] ? -r_qb : r_qb;
                        n_st   = C_MUL;
                        n_done = 1'b0;
                    end
                    OP_MULK: begin
                        n_acc  = '0;
                        n_mc   = r_qa;
                        n_mp   = BW'(r_cmd.imm);
                        n_st   = C_MUL;
                        n_done = 1'b0;
                    end
                    OP_CGT: begin
                        if (!($signed(r_qa) > $signed(r_qb))) n_ok[r_cmd.sel[1:0]] = 1'b0;
                    end
                    OP_CLT: begin
                        if (!($signed(r_qa) < $signed(r_qb))) n_ok[r_cmd.sel[1:0]] = 1'b0;
                    end
                    OP_DIV: begin
                        if (r_qa[BW-1] || r_qa == '0 || r_qb == '0) begin
                            n_quot[r_cmd.sel[2:0]] = '0;
                        end else if (num_sh >= den_sh) begin
                            n_quot[r_cmd.sel[2:0]] = '1;
                        end else begin
                            n_acc  = num_sh;
                            n_mc   = r_qb << (OUT_W - 1);
                            n_cnt  = 5'(OUT_W - 1);
                            n_q    = '0;
                            n_st   = C_DIV;
                            n_done = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            C_MUL: begin
                if (r_mp == '0) begin
                    we     = 1'b1;
                    wd     = r_acc;
                    n_st   = C_IDLE;
                    n_done = 1'b1;
                end else begin
                    if (r_mp[0]) n_acc = r_acc + r_mc;
                    n_mc = r_mc << 1;
                    n_mp = r_mp >> 1;
                end
            end
            C_DIV: begin
                if (r_acc >= r_mc) begin
                    n_acc        = r_acc - r_mc;
                    n_q[r_cnt]   = 1'b1;
                end
                n_mc = r_mc >> 1;
                if (r_cnt == '0) begin
                    n_quot[r_cmd.sel[2:0]] = n_q;
                    n_st   = C_IDLE;
                    n_done = 1'b1;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: n_st = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= C_IDLE;
            r_done <= 1'b0;
            r_ok   <= '0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
            r_ok   <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_acc  <= n_acc;
        r_mc   <= n_mc;
        r_mp   <= n_mp;
        r_cnt  <= n_cnt;
        r_q    <= n_q;
        r_quot <= n_quot;
    end

    always_ff @(posedge i_clk) begin
        if (r_st == C_RD) begin
            r_qa <= r_rf[r_cmd.a];
            r_qb <= r_rf[r_cmd.b];
        end
        if (we) r_rf[r_cmd.dst] <= wd;
    end

endmodule

### rtl/moment_invariant_classifier.sv
// ----------------------------------------------------------------------------
// moment_invariant_classifier: Hu moment invariants of one pixel segment
// Accumulates raw moments per pixel and, on the last pixel, runs a short
// program on a shared wide arithmetic unit to form the invariants.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix takes one pixel per transfer (pixel_x, pixel_y, last_pixel). While
//   a segment is being collected, a pixel is taken in every cycle.
//   After the transfer marked last_pixel, ready stays low while the moment
//   pipeline drains and the program runs on the shared unit: 153 commands,
//   each multiply stepping once per significant multiplier bit and each
//   divide that is not settled at once as zero or saturated producing one
//   quotient bit per step. The time of a segment end is set mostly by the
//   bit-serial multiplier.
//   A segment with a count overflow skips the program and reports status 2.
//   o_res presents one result per segment from an output register; the next
//   segment is collected while that result waits. If the receiver stalls
//   through a whole segment, the block holds before loading the next result.
//   Reset clears the accumulators, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module moment_invariant_classifier (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mic_pix_if.sink   i_pix,
    mic_res_if.source o_res
);
    import mic_pkg::*;

    typedef enum logic [3:0] {
        T_ACC   = 4'b0001,
        T_DRAIN = 4'b0010,
        T_RUN   = 4'b0100,
        T_OUT   = 4'b1000
    } t_tst;

    t_tst                          r_st, n_st;
    logic [1:0]                    r_drn, n_drn;
    logic [PC_W-1:0]               r_pc, n_pc;
    logic                          r_start, n_start;
    logic [1:0]                    r_status, n_status;
    logic                          r_valid, n_valid;
    logic [NUM_INV-1:0][OUT_W-1:0] r_inv, n_inv;
    logic [NUM_LETTERS-1:0]        r_let, n_let;
    logic [1:0]                    r_ost, n_ost;
    logic                          pix_xfer;
    logic                          clr;
    t_sums                         sums;
    logic                          core_done;
    logic [NUM_INV-1:0][OUT_W-1:0] quot;
    logic [NUM_LETTERS-1:0]        ok;

    assign i_pix.ready = (r_st == T_ACC);
    assign pix_xfer    = i_pix.valid && i_pix.ready;

    mic_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pix_xfer),
        .i_x     (i_pix.pixel_x[COORD_BITS-1:0]),
        .i_y     (i_pix.pixel_y[COORD_BITS-1:0]),
        .i_clr   (clr),
        .o_sums  (sums)
    );

    mic_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_cmd   (prog(r_pc)),
        .i_sums  (sums),
        .o_done  (core_done),
        .o_quot  (quot),
        .o_ok    (ok)
    );

    always_comb begin
        n_st     = r_st;
        n_drn    = r_drn;
        n_pc     = r_pc;
        n_start  = 1'b0;
        n_status = r_status;
        n_valid  = r_valid && !o_res.ready;
        n_inv    = r_inv;
        n_let    = r_let;
        n_ost    = r_ost;
        clr      = 1'b0;
        unique case (r_st)
            T_ACC: begin
                if (pix_xfer && i_pix.last_pixel) begin
                    n_st  = T_DRAIN;
                    n_drn = 2'd2;
                end
            end
            T_DRAIN: begin
                if (r_drn != '0) begin
                    n_drn = r_drn - 1'b1;
                end else begin
                    if (sums.n[COUNT_BITS]) begin
                        n_status = ST_OVFL;
                        n_st     = T_OUT;
                    end else if (sums.n == '0) begin
                        n_status = ST_EMPTY;
                        n_st     = T_OUT;
                    end else begin
                        n_status = ST_OK;
                        n_pc     = '0;
                        n_start  = 1'b1;
                        n_st     = T_RUN;
                    end
                end
            end
            T_RUN: begin
                if (core_done) begin
                    if (r_pc == PC_W'(PROG_LEN - 1)) begin
                        n_st = T_OUT;
                    end else begin
                        n_pc    = r_pc + 1'b1;
                        n_start = 1'b1;
                    end
                end
            end
            T_OUT: begin
                if (!r_valid || o_res.ready) begin
                    n_valid = 1'b1;
                    n_ost   = r_status;
                    n_inv   = (r_status == ST_OK) ? quot : '0;
                    n_let   = (r_status == ST_OK) ? ok : '0;
                    clr     = 1'b1;
                    n_st    = T_ACC;
                end
            end
            default: n_st = T_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= T_ACC;
            r_drn   <= '0;
            r_pc    <= '0;
            r_start <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_drn   <= n_drn;
            r_pc    <= n_pc;
            r_start <= n_start;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_inv    <= n_inv;
        r_let    <= n_let;
        r_ost    <= n_ost;
    end

    assign o_res.valid        = r_valid;
    assign o_res.inv_m1       = r_inv[0];
    assign o_res.inv_m2       = r_inv[1];
    assign o_res.inv_m3       = r_inv[2];
    assign o_res.inv_m4       = r_inv[3];
    assign o_res.inv_m7       = r_inv[4];
    assign o_res.looks_like_c = r_let[LT_C];
    assign o_res.looks_like_i = r_let[LT_I];
    assign o_res.looks_like_t = r_let[LT_T];
    assign o_res.status       = r_ost;

endmodule

### sim/tb_moment_invariant_classifier.sv
// ----------------------------------------------------------------------------
// tb_moment_invariant_classifier: self-checking bench for the Hu classifier
// Feeds pixel segments over the input channel with random gaps, predicts the
// invariants, letter flags and status exactly with wide integers, and checks
// every result transfer in order against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_moment_invariant_classifier;
    import mic_pkg::*;

    typedef logic signed [639:0] wide_t;

    typedef struct {
        logic [OUT_W-1:0] m1, m2, m3, m4, m7;
        logic             is_c, is_i, is_t;
        logic [1:0]       st;
    } shape_t;

    class moment_scoreboard;
        wide_t  n, sx, sy, sxx, syy, sxy, sxxx, syyy, sxxy, sxyy;
        shape_t expected_shapes[$];
        bit     failed;

        function new();
            clear_sums();
            failed = 0;
        endfunction

        function void clear_sums();
            n = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
            sxxx = 0; syyy = 0; sxxy = 0; sxyy = 0;
        endfunction

        // Floor of num/den in unsigned fixed point, saturated.
        function logic [OUT_W-1:0] fixed_of(wide_t num, wide_t den);
            wide_t q;
            if (num <= 0 || den == 0) return '0;
            q = (num <<< OUT_FRAC_BITS) / den;
            if (q >= (wide_t'(1) <<< 32)) return '1;
            return q[OUT_W-1:0];
        endfunction

        // True when num/den < hi and, for a nonzero lo, lo < num/den; bounds in units of 1/10000.
        function bit in_window(wide_t num, wide_t den, int lo, int hi);
            wide_t l;
            l = (num < 0) ? wide_t'(0) : num * 10000;
            if (lo != 0 && l <= den * lo) return 0;
            return l < den * hi;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, logic last);
            wide_t  x, y, a20, a02, a11, b30, b03, b21, b12, n2, n3, n6, n9;
            wide_t  u[5], d[5];
            shape_t r;
            x = wide_t'(px & ((1 << COORD_BITS) - 1));
            y = wide_t'(py & ((1 << COORD_BITS) - 1));
            if (n < (wide_t'(1) <<< COUNT_BITS) - 1) begin
                n += 1; sx += x; sy += y;
                sxy += x * y; sxx += x * x; syy += y * y;
                sxxy += x * x * y; sxyy += x * y * y;
                sxxx += x * x * x; syyy += y * y * y;
            end else begin
                n = wide_t'(1) <<< COUNT_BITS;
            end
            if (!last) return;
            r = '{default: '0};
            if (n > (wide_t'(1) <<< COUNT_BITS) - 1) r.st = ST_OVFL;
            else if (n == 0) r.st = ST_EMPTY;
            else r.st = ST_OK;
            if (r.st == ST_OK) begin
                n2 = n * n; n3 = n2 * n; n6 = n3 * n3; n9 = n6 * n3;
                a20 = n * sxx - sx * sx;
                a02 = n * syy - sy * sy;
                a11 = n * sxy - sx * sy;
                b30 = n2 * sxxx - 3 * n * sxx * sx + 2 * sx * sx * sx;
                b03 = n2 * syyy - 3 * n * syy * sy + 2 * sy * sy * sy;
                b21 = n2 * sxxy - 2 * n * sxy * sx - n * sxx * sy + 2 * sy * sx * sx;
                b12 = n2 * sxyy - 2 * n * sxy * sy - n * syy * sx + 2 * sx * sy * sy;
                u[0] = a20 + a02;                                 d[0] = n3;
                u[1] = (a20 - a02) * (a20 - a02) + 4 * a11 * a11;  d[1] = n6;
                u[2] = (b30 - 3 * b12) * (b30 - 3 * b12)
                     + (3 * b21 - b03) * (3 * b21 - b03);          d[2] = n9;
                u[3] = (b30 + b12) * (b30 + b12) + (b21 + b03) * (b21 + b03);
                d[3] = n9;
                u[4] = a20 * a02 - a11 * a11;                      d[4] = n6;
                r.m1 = fixed_of(u[0], d[0]);
                r.m2 = fixed_of(u[1], d[1]);
                r.m3 = fixed_of(u[2], d[2]);
                r.m4 = fixed_of(u[3], d[3]);
                r.m7 = fixed_of(u[4], d[4]);
                r.is_c = in_window(u[0], d[0], 3500, 5300) && in_window(u[1], d[1], 0, 500)
                      && in_window(u[2], d[2], 10, 300) && in_window(u[3], d[3], 10, 200)
                      && in_window(u[4], d[4], 200, 700);
                r.is_i = in_window(u[0], d[0], 2800, 7000) && in_window(u[1], d[1], 600, 3200)
                      && in_window(u[2], d[2], 0, 20) && in_window(u[3], d[3], 0, 20)
                      && in_window(u[4], d[4], 10, 100);
                r.is_t = in_window(u[0], d[0], 3000, 7000) && in_window(u[1], d[1], 500, 3500)
                      && in_window(u[2], d[2], 20, 500) && in_window(u[3], d[3], 5, 300)
                      && in_window(u[4], d[4], 100, 190);
            end
            expected_shapes.push_back(r);
            clear_sums();
        endfunction

        function void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v) begin
                $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
                failed = 1;
            end
        endfunction

        function void check_shape(shape_t a);
            shape_t e;
            if (expected_shapes.size() == 0) begin
                $display("%0t unexpected result: expected none actual status %0d", $time, a.st);
                failed = 1;
                return;
            end
            e = expected_shapes.pop_front();
            check_field("inv_m1", e.m1, a.m1);
            check_field("inv_m2", e.m2, a.m2);
            check_field("inv_m3", e.m3, a.m3);
            check_field("inv_m4", e.m4, a.m4);
            check_field("inv_m7", e.m7, a.m7);
            check_field("looks_like_c", e.is_c, a.is_c);
            check_field("looks_like_i", e.is_i, a.is_i);
            check_field("looks_like_t", e.is_t, a.is_t);
            check_field("status", e.st, a.st);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    mic_pix_if pix ();
    mic_res_if res ();

    moment_invariant_classifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix.sink),
        .o_res   (res.source)
    );

    moment_scoreboard shapes = new();
    bit               no_gaps;
    int               rx_stall;
    int               pixels_sent;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // Receiver: stall count is redrawn after every result transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            shapes.check_shape('{res.inv_m1, res.inv_m2, res.inv_m3, res.inv_m4, res.inv_m7,
                                 res.looks_like_c, res.looks_like_i, res.looks_like_t,
                                 res.status});
            rx_stall <= no_gaps ? 0 : $urandom_range(0, 11);
        end else if (rx_stall > 0 && !res.ready) begin
            rx_stall <= rx_stall - 1;
        end
    end

    always @(negedge i_clk) begin
        res.ready <= (rx_stall == 0);
    end

    // Called just after a falling edge; returns just after the falling edge
    // that follows the transfer.
    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                              input logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix.valid      <= 1'b1;
        pix.pixel_x    <= x;
        pix.pixel_y    <= y;
        pix.last_pixel <= last;
        do @(posedge i_clk); while (!(pix.valid && pix.ready));
        shapes.note_pixel(x, y, last);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // A blob of random pixels around a random center with the given spread.
    task automatic send_segment(input int len, input int spread);
        int cx, cy, x, y;
        cx = $urandom_range(0, 2047);
        cy = $urandom_range(0, 2047);
        for (int k = 0; k < len; k++) begin
            x = cx + $urandom_range(0, spread) - spread / 2;
            y = cy + $urandom_range(0, spread) - spread / 2;
            x = (x < 0) ? 0 : (x > 2047) ? 2047 : x;
            y = (y < 0) ? 0 : (y > 2047) ? 2047 : y;
            send_pixel(PIX_W'(x), PIX_W'(y), k == len - 1);
        end
    endtask

    // Letter-like strokes: a bar, or a bar with a crossbar on top.
    task automatic send_stroke(input bit with_top);
        int bx, by, h;
        bx = $urandom_range(20, 2000);
        by = $urandom_range(20, 2000);
        h  = $urandom_range(6, 14);
        for (int k = 0; k < h; k++)
            send_pixel(PIX_W'(bx + (k % 2)), PIX_W'(by + k), !with_top && k == h - 1);
        if (with_top)
            for (int k = -4; k <= 4; k++)
                send_pixel(PIX_W'(bx + k), PIX_W'(by - 1), k == 4);
    endtask

    initial begin
        pix.valid      = 1'b0;
        pix.pixel_x    = '0;
        pix.pixel_y    = '0;
        pix.last_pixel = 1'b0;
        res.ready      = 1'b0;
        rx_stall       = 0;
        no_gaps        = 0;
        pixels_sent    = 0;
        i_rst_n        = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single pixels at the corners give all-zero invariants.
        send_pixel(11'd0, 11'd0, 1'b1);
        send_pixel(11'd2047, 11'd2047, 1'b1);
        // Two opposite corners, then all four corners.
        send_pixel(11'd0, 11'd2047, 1'b0);
        send_pixel(11'd2047, 11'd0, 1'b1);
        send_pixel(11'd0, 11'd0, 1'b0);
        send_pixel(11'd2047, 11'd0, 1'b0);
        send_pixel(11'd0, 11'd2047, 1'b0);
        send_pixel(11'd2047, 11'd2047, 1'b1);
        // A horizontal line and a repeated pixel.
        for (int k = 0; k < 5; k++) send_pixel(11'd1000 + 11'(k), 11'd5, k == 4);
        for (int k = 0; k < 3; k++) send_pixel(11'h555, 11'h2aa, k == 2);
        send_stroke(1'b0);

        while (pixels_sent < 420) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 4))
                0:       send_segment($urandom_range(1, 3), 2047);
                1:       send_stroke($urandom_range(0, 1));
                2:       send_segment($urandom_range(2, 30), 4095);
                default: send_segment($urandom_range(2, 20), $urandom_range(1, 40));
            endcase
        end
        no_gaps = 0;
        pix.valid <= 1'b0;

        while (shapes.expected_shapes.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (!shapes.failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #80000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
